### hw/rtl/slid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slid_pkg
// Shared constants, status codes and cell control type for the sorted list.
// ----------------------------------------------------------------------------
package slid_pkg;

  localparam int CAPACITY    = 16;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic                       do_ins;
    logic                       do_del;
    logic signed [VALUE_W-1:0]  value;
  } cell_ctl_t;

endpackage

### hw/rtl/slid_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slid_cell
// One list position: holds an entry, compares it with the broadcast word and
// takes the broadcast word or its left or right neighbor's entry on a change.
// ----------------------------------------------------------------------------
module slid_cell (
  input  logic                               clk,
  input  slid_pkg::cell_ctl_t                ctl,
  input  logic                               occ,
  input  logic                               left_ins,
  input  logic signed [slid_pkg::VALUE_W-1:0] left_data,
  input  logic signed [slid_pkg::VALUE_W-1:0] right_data,
  output logic signed [slid_pkg::VALUE_W-1:0] data_r,
  output logic                               ins_here,
  output logic                               eq
);
  import slid_pkg::*;

  logic signed [VALUE_W-1:0] data_nxt;
  logic                      del_here;

  assign ins_here = !occ || (ctl.value < data_r);
  assign del_here = occ && !(data_r < ctl.value);
  assign eq       = occ && (data_r == ctl.value);

  always_comb begin
    data_nxt = data_r;
    if (ctl.do_ins) begin
      if (left_ins) begin
        data_nxt = left_data;
      end else if (ins_here) begin
        data_nxt = ctl.value;
      end
    end else if (ctl.do_del && del_here) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

### hw/rtl/sorted_list_insert_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Ascending list of signed words kept in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Takes one word per clock: busy stays low, and each accepted word gives its
// result in the next cycle on out_status and out_entry_count, marked by a
// one-cycle out_valid. All cells compare against the broadcast word in the
// same cycle and shift toward or away from the chosen position at the edge.
// Results cannot be held off; a receiver must take each one in the cycle it
// appears.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_mode,
  input  logic signed [slid_pkg::VALUE_W-1:0]  in_value,
  output logic                                 out_valid,
  output logic [slid_pkg::STATUS_W-1:0]        out_status,
  output logic [slid_pkg::COUNT_OUT_W-1:0]     out_entry_count
);
  import slid_pkg::*;

  logic                      accept;
  logic                      full;
  logic                      empty;
  logic                      found;
  cell_ctl_t                 ctl;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic [STATUS_W-1:0]       status_r;
  logic [STATUS_W-1:0]       status_nxt;
  logic                      valid_r;
  logic [CAPACITY-1:0]       occ;
  logic [CAPACITY-1:0]       ins_here;
  logic [CAPACITY-1:0]       eq;
  logic signed [VALUE_W-1:0] cell_data [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);
  assign found  = |eq;

  assign ctl.do_ins = accept && (in_mode == MODE_INSERT) && !full;
  assign ctl.do_del = accept && (in_mode == MODE_DELETE) && found;
  assign ctl.value  = in_value;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic                      left_ins;
    logic signed [VALUE_W-1:0] left_data;
    logic signed [VALUE_W-1:0] right_data;

    assign occ[k] = (CNT_W'(k) < count_r);

    if (k == 0) begin : g_first
      assign left_ins  = 1'b0;
      assign left_data = '0;
    end else begin : g_mid
      assign left_ins  = ins_here[k-1];
      assign left_data = cell_data[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[k];
    end else begin : g_inner
      assign right_data = cell_data[k+1];
    end

    slid_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ[k]),
      .left_ins   (left_ins),
      .left_data  (left_data),
      .right_data (right_data),
      .data_r     (cell_data[k]),
      .ins_here   (ins_here[k]),
      .eq         (eq[k])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = status_r;
    if (accept) begin
      if (in_mode == MODE_INSERT) begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_INSERTED;
          count_nxt  = count_r + CNT_W'(1);
        end
      end else if (empty) begin
        status_nxt = ST_EMPTY;
      end else if (found) begin
        status_nxt = ST_DELETED;
        count_nxt  = count_r - CNT_W'(1);
      end else begin
        status_nxt = ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_entry_count = COUNT_OUT_W'(count_r);

endmodule

### hw/rtl/slid_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slid_checker
// Port-level checks on result timing and entry count bookkeeping.
// ----------------------------------------------------------------------------
module slid_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 out_valid,
  input logic [slid_pkg::STATUS_W-1:0]        out_status,
  input logic [slid_pkg::COUNT_OUT_W-1:0]     out_entry_count
);
  import slid_pkg::*;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted word gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without accepted word");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid) && out_status == ST_INSERTED) |->
      out_entry_count == COUNT_OUT_W'($past(out_entry_count) + 1'b1))
    else $error("insert did not advance count");

  a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid) && out_status == ST_DELETED) |->
      out_entry_count == COUNT_OUT_W'($past(out_entry_count) - 1'b1))
    else $error("delete did not drop count");

  a_hold_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid) &&
     (out_status == ST_FULL || out_status == ST_EMPTY ||
      out_status == ST_NOT_FOUND)) |->
      out_entry_count == $past(out_entry_count))
    else $error("failed operation changed count");

endmodule

bind sorted_list_insert_delete slid_checker u_slid_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_entry_count (out_entry_count)
);
